// ===== rtl/nearest_neighbour_scale_blit_unit_assert.svh =====
// assertion macros for the scaler
`ifndef NEAREST_NEIGHBOUR_SCALE_BLIT_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOUR_SCALE_BLIT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NNSB_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("nnsb: implication check failed");
`define NNSB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("nnsb: next-cycle check failed");
`else
`define NNSB_ASSERT_IMPLY(label, clk, rst, a, b)
`define NNSB_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/nnsb_pkg.sv =====
`timescale 1ns / 1ps
package nnsb_pkg;
  localparam int SRC_MAX_W = 1024;
  localparam int SRC_MAX_H = 512;
  localparam int SRC_COL_W = $clog2(SRC_MAX_W);
  localparam int SRC_ROW_W = $clog2(SRC_MAX_H);
  localparam int ADDR_W    = SRC_COL_W + SRC_ROW_W;
  localparam int SCR_W     = 10;
  localparam int PIX_W     = 8;
  localparam int ENTRY_W   = PIX_W + 1;
  localparam int SW_W      = 11;
  localparam int SH_W      = 10;
  localparam int POS_W     = 13;
  localparam int DIM_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int NUM_W     = 22;
  localparam int QUO_W     = SRC_COL_W;
  localparam int DIV_STAGES = QUO_W;
  localparam int NSTAGE    = DIV_STAGES + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W  = 3'd0,
    CFG_SRC_H  = 3'd1,
    CFG_LEFT   = 3'd2,
    CFG_TOP    = 3'd3,
    CFG_RECT_W = 3'd4,
    CFG_RECT_H = 3'd5,
    CFG_MODE   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_OPAQUE = 2'd1,
    MODE_TR_IDX = 2'd2,
    MODE_TR_COV = 2'd3
  } mode_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  // per-stage control carried beside the divider data
  typedef struct packed {
    op_t                op;
    logic               draw;
    logic               clear;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
  } tag_t;
endpackage

// ===== rtl/nnsb_if.sv =====
`timescale 1ns / 1ps
interface nnsb_req_if;
  import nnsb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [SRC_COL_W-1:0] source_col;
  logic [SRC_ROW_W-1:0] source_row;
  logic [PIX_W-1:0]     pixel_index;
  logic                 covered;
  logic [SCR_W-1:0]     screen_col;
  logic [SCR_W-1:0]     screen_row;
  modport source (output valid, operation, source_col, source_row, pixel_index, covered,
                  screen_col, screen_row, input ready);
  modport sink (input valid, operation, source_col, source_row, pixel_index, covered,
                screen_col, screen_row, output ready);
endinterface

interface nnsb_res_if;
  import nnsb_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, action, pixel_out, input ready);
  modport sink (input valid, action, pixel_out, output ready);
endinterface

// ===== rtl/nnsb_div.sv =====
`timescale 1ns / 1ps
module nnsb_div (
  input  logic                            clk,
  input  logic [nnsb_pkg::DIV_STAGES-1:0] en,
  input  logic [nnsb_pkg::NUM_W-1:0]      num,
  input  logic [nnsb_pkg::DIM_W-1:0]      den,
  output logic [nnsb_pkg::QUO_W-1:0]      quo
);
  import nnsb_pkg::*;

  // one quotient bit per stage, msb first
  logic [NUM_W-1:0] rem [DIV_STAGES];
  logic [QUO_W-1:0] q   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0] rin;
    logic [QUO_W-1:0] qin;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    if (k == 0) begin : g_first
      assign rin = num;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem[k-1];
      assign qin = q[k-1];
    end
    assign dsh = {{(NUM_W-DIM_W){1'b0}}, den} << (DIV_STAGES-1-k);
    assign ge  = rin >= dsh;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? rin - dsh : rin;
        q[k]   <= qin | (QUO_W'(ge) << (DIV_STAGES-1-k));
      end
    end
  end

  assign quo = q[DIV_STAGES-1];
endmodule

// ===== rtl/nnsb_store.sv =====
`timescale 1ns / 1ps
module nnsb_store (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          we,
  input  logic [nnsb_pkg::ADDR_W-1:0]   addr,
  input  logic [nnsb_pkg::ENTRY_W-1:0]  wdata,
  output logic [nnsb_pkg::ENTRY_W-1:0]  rdata
);
  import nnsb_pkg::*;

  logic [ENTRY_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end
endmodule

// ===== rtl/nearest_neighbour_scale_blit_unit.sv =====
`timescale 1ns / 1ps
// channel  dir  fields
// request  in   operation source_col source_row pixel_index covered screen_col screen_row
// result   out  action pixel_out
// cfg      in   cfg_write cfg_index cfg_data (plain register writes)
//
// one item per cycle sustained while results are taken; stages in order: entry stage, multiplier,
// ten restoring divider stages (one quotient bit each), then the store read.
// writes and reads hit the single-port store in item order at the last stage,
// so a render always sees every earlier write.
// synchronous reset clears valid bits and sets the config registers to defaults; the store is undefined.
// a stalled result holds the pipe back only where stages are full.
module nearest_neighbour_scale_blit_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [nnsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnsb_pkg::CFG_DAT_W-1:0] cfg_data,
  nnsb_req_if.sink                       request,
  nnsb_res_if.source                     result
);
  import nnsb_pkg::*;

  localparam int LAST = NSTAGE - 1;

  logic [SW_W-1:0]  source_width;
  logic [SH_W-1:0]  source_height;
  logic [POS_W-1:0] rect_left;
  logic [POS_W-1:0] rect_top;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;
  mode_t            draw_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SW_W'(1);
      source_height <= SH_W'(1);
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      draw_mode     <= MODE_PLAIN;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SRC_W:  source_width  <= cfg_data[SW_W-1:0];
        CFG_SRC_H:  source_height <= cfg_data[SH_W-1:0];
        CFG_LEFT:   rect_left     <= cfg_data;
        CFG_TOP:    rect_top      <= cfg_data;
        CFG_RECT_W: rect_width    <= cfg_data[DIM_W-1:0];
        CFG_RECT_H: rect_height   <= cfg_data[DIM_W-1:0];
        CFG_MODE:   draw_mode     <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] free;
  tag_t              tag [NSTAGE];

  always_comb begin
    free[LAST] = !v[LAST] || result.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      free[i] = !v[i] || free[i+1];
    end
  end

  assign request.ready = free[0];

  // entry stage: rectangle test and offsets
  logic [SW_W-1:0]  sw;
  logic [SH_W-1:0]  sh;
  logic             enabled;
  logic [POS_W:0]   u;
  logic [POS_W:0]   w;
  logic             in_x;
  logic             in_y;
  tag_t             tag_in;

  assign sw = (source_width > SW_W'(SRC_MAX_W)) ? SW_W'(SRC_MAX_W) : source_width;
  assign sh = (source_height > SH_W'(SRC_MAX_H)) ? SH_W'(SRC_MAX_H) : source_height;
  assign enabled = (source_width != '0) && (source_height != '0);
  assign u = {{(POS_W+1-SCR_W){1'b0}}, request.screen_col} - {rect_left[POS_W-1], rect_left};
  assign w = {{(POS_W+1-SCR_W){1'b0}}, request.screen_row} - {rect_top[POS_W-1], rect_top};
  assign in_x = !u[POS_W] && (u[POS_W-1:0] < {1'b0, rect_width});
  assign in_y = !w[POS_W] && (w[POS_W-1:0] < {1'b0, rect_height});

  always_comb begin
    tag_in.op    = op_t'(request.operation);
    tag_in.draw  = enabled && in_x && in_y;
    tag_in.clear = enabled && !(in_x && in_y) && (draw_mode == MODE_OPAQUE);
    tag_in.waddr = {request.source_row, request.source_col};
    tag_in.wdata = {request.covered, request.pixel_index};
  end

  logic [DIM_W-1:0] u1;
  logic [DIM_W-1:0] w1;
  logic [NUM_W-1:0] ncol;
  logic [NUM_W-1:0] nrow;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[0]) v[0] <= request.valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (free[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) begin
      tag[0] <= tag_in;
      u1     <= u[DIM_W-1:0] + DIM_W'(1);
      w1     <= w[DIM_W-1:0] + DIM_W'(1);
    end
    if (free[1]) begin
      tag[1] <= tag[0];
      // ceil(n/d)-1 is floor((n-1)/d) for n >= 1
      ncol   <= {{(NUM_W-DIM_W){1'b0}}, u1} * {{(NUM_W-SW_W){1'b0}}, sw} - NUM_W'(1);
      nrow   <= {{(NUM_W-DIM_W){1'b0}}, w1} * {{(NUM_W-SH_W){1'b0}}, sh} - NUM_W'(1);
    end
    for (int i = 2; i < NSTAGE; i++) begin
      if (free[i]) tag[i] <= tag[i-1];
    end
  end

  logic [QUO_W-1:0] qcol;
  logic [QUO_W-1:0] qrow;

  nnsb_div u_div_col (
    .clk (clk),
    .en  (free[LAST-1:2]),
    .num (ncol),
    .den (rect_width),
    .quo (qcol)
  );

  nnsb_div u_div_row (
    .clk (clk),
    .en  (free[LAST-1:2]),
    .num (nrow),
    .den (rect_height),
    .quo (qrow)
  );

  // store access as the item moves into the result stage
  tag_t               tag_m;
  logic               st_en;
  logic               st_we;
  logic [ADDR_W-1:0]  st_addr;
  logic [ENTRY_W-1:0] rdata;

  assign tag_m   = tag[LAST-1];
  assign st_en   = free[LAST] && v[LAST-1];
  assign st_we   = (tag_m.op == OP_WRITE);
  assign st_addr = st_we ? tag_m.waddr : {qrow[SRC_ROW_W-1:0], qcol[SRC_COL_W-1:0]};

  nnsb_store u_store (
    .clk   (clk),
    .en    (st_en),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (tag_m.wdata),
    .rdata (rdata)
  );

  tag_t tag_o;
  logic skip;
  logic put;

  assign tag_o = tag[LAST];
  assign skip  = ((draw_mode == MODE_TR_IDX) && (rdata[PIX_W-1:0] == '0)) ||
                 ((draw_mode == MODE_TR_COV) && !rdata[PIX_W]);
  assign put   = (tag_o.op == OP_RENDER) && tag_o.draw && !skip;

  assign result.valid     = v[LAST];
  assign result.action    = put || ((tag_o.op == OP_RENDER) && tag_o.clear);
  assign result.pixel_out = put ? rdata[PIX_W-1:0] : '0;

`include "nearest_neighbour_scale_blit_unit_assert.svh"

  `NNSB_ASSERT_IMPLY(a_idle_zero, clk, rst, result.valid && !result.action, result.pixel_out == '0)
  `NNSB_ASSERT_IMPLY(a_full_stall, clk, rst, (&v) && !result.ready, !request.ready)
  `NNSB_ASSERT_NEXT(a_occupancy, clk, rst, !(request.valid && request.ready) && !(result.valid && result.ready), $countones(v) == $past($countones(v)))

endmodule
